// ===== src/io_port_range_allocator_unit_defines.svh =====
// Assertion macros for the I/O port range allocator.
// Used by io_port_range_allocator_unit.sv; expects i_clk and i_rst_n in scope.
`ifndef IO_PORT_RANGE_ALLOCATOR_UNIT_DEFINES_SVH
`define IO_PORT_RANGE_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define IOPRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IOPRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/iopra_pkg.sv =====
// Shared types and constants of the I/O port range allocator.
// No dependencies.
`default_nettype none
package iopra_pkg;
    localparam int unsigned ENTRIES_DEF = 32;
    localparam int unsigned PTR_W       = 6;
    localparam logic [PTR_W-1:0] PTR_NIL = 6'd63;

    localparam logic [15:0] FLOOR_RST = 16'h0400;
    localparam logic [16:0] LIMIT_RST = 17'h10000;

    localparam logic [15:0] VGA_A_LO = 16'h02b0;
    localparam logic [16:0] VGA_A_HI = 17'h002e0;
    localparam logic [15:0] VGA_B_LO = 16'h03c0;
    localparam logic [16:0] VGA_B_HI = 17'h003db;

    typedef enum logic [2:0] {
        OP_FIXED  = 3'd0,
        OP_SEARCH = 3'd1,
        OP_RESV   = 3'd2,
        OP_FREE   = 3'd3,
        OP_CHECK  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOSPC  = 2'd1,
        ST_NOENT  = 2'd2,
        ST_DENIED = 2'd3
    } t_status;

    localparam logic REG_FLOOR = 1'b0;
    localparam logic REG_LIMIT = 1'b1;
endpackage
`default_nettype wire

// ===== src/iopra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module iopra_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/io_port_range_allocator_unit.sv =====
// I/O port range allocator: start-sorted linked table of port ranges.
// Each item walks the list; each visited entry passes a RAM read state and an evaluate state;
// an aligned search also runs the remainder unit for each entry it steps past above the floor.
// Insert adds the states S_INSR, S_INS1 and S_INS2, free adds S_FR1 and S_FR2, before S_DONE.
// One item in flight, ready again once the result is offered; sync low reset empties the table.
// Depends on iopra_pkg, iopra_ram and io_port_range_allocator_unit_defines.svh.
`default_nettype none
`include "io_port_range_allocator_unit_defines.svh"
module io_port_range_allocator_unit #(
    parameter int unsigned ENTRIES = iopra_pkg::ENTRIES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [2:0]  i_opcode,
    input  wire  [15:0] i_port,
    input  wire  [16:0] i_size,
    input  wire  [15:0] i_align,
    input  wire  [16:0] i_range_end,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_result_port,
    output logic [31:0] o_table_version,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import iopra_pkg::*;

    localparam int unsigned AW = $clog2(ENTRIES);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RD   = 10'b0000000010,
        S_EV   = 10'b0000000100,
        S_DIV  = 10'b0000001000,
        S_INSR = 10'b0000010000,
        S_INS1 = 10'b0000100000,
        S_INS2 = 10'b0001000000,
        S_FR1  = 10'b0010000000,
        S_FR2  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [2:0]  r_op;
    logic [15:0] r_port, r_align;
    logic [16:0] r_size, r_rend;
    logic [PTR_W-1:0] r_cur, n_cur, r_prev, n_prev, r_ent, n_ent, r_nx, n_nx;
    logic [PTR_W-1:0] r_free, n_free, r_head, n_head;
    logic [16:0] r_p, n_p, r_dvd, n_dvd;
    logic [15:0] r_rem, n_rem;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_count, n_count;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_res, n_res;
    logic [15:0] r_floor;
    logic [16:0] r_limit;
    logic [ENTRIES-1:0] r_resv, r_lvld;
    logic [AW-1:0] r_raddr;

    logic          rng_we, lnk_we, resv_clr, resv_set;
    logic [AW-1:0] rng_wa, lnk_wa, raddr;
    logic [32:0]   rng_wd, rng_q;
    logic [PTR_W-1:0] lnk_wd, lnk_ram_q, lnk_q;

    logic [15:0] rs;
    logic [16:0] re;
    logic [17:0] end0, psz;
    logic [16:0] rem_sh;
    logic        cur_nil, free_nil, in_acc, out_go;
    logic [31:0] ver;

    iopra_ram #(.WIDTH(33), .DEPTH(ENTRIES)) u_rng (
        .i_clk(i_clk), .i_we(rng_we), .i_waddr(rng_wa), .i_wdata(rng_wd),
        .i_raddr(raddr), .o_rdata(rng_q)
    );
    iopra_ram #(.WIDTH(PTR_W), .DEPTH(ENTRIES)) u_lnk (
        .i_clk(i_clk), .i_we(lnk_we), .i_waddr(lnk_wa), .i_wdata(lnk_wd),
        .i_raddr(raddr), .o_rdata(lnk_ram_q)
    );

    // links never written since reset read as the initial free chain
    always_comb begin
        if (r_lvld[r_raddr]) begin
            lnk_q = lnk_ram_q;
        end else if (r_raddr == AW'(ENTRIES - 1)) begin
            lnk_q = PTR_NIL;
        end else begin
            lnk_q = PTR_W'(r_raddr) + PTR_W'(1);
        end
    end

    assign rs       = rng_q[32:17];
    assign re       = rng_q[16:0];
    assign end0     = {2'b00, r_port} + {1'b0, r_size};
    assign psz      = {1'b0, r_p} + {1'b0, r_size};
    assign cur_nil  = (r_cur >= PTR_W'(ENTRIES));
    assign free_nil = (r_free >= PTR_W'(ENTRIES));
    assign rem_sh   = {r_rem, r_dvd[16]};
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_go   = !o_out_valid || i_out_ready;
    assign ver      = r_count + ((r_op == OP_FREE) ? 32'd1 : 32'd0);

    assign o_in_ready = (r_state == S_IDLE);
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_LIMIT) ? {15'd0, r_limit} : {16'd0, r_floor};

    always_comb begin
        n_state = r_state; n_cur = r_cur; n_prev = r_prev; n_ent = r_ent; n_nx = r_nx;
        n_free = r_free; n_head = r_head; n_p = r_p; n_dvd = r_dvd; n_rem = r_rem;
        n_cnt = r_cnt; n_count = r_count; n_status = r_status; n_res = r_res;
        rng_we = 1'b0; rng_wa = r_free[AW-1:0]; rng_wd = {r_p[15:0], psz[16:0]};
        lnk_we = 1'b0; lnk_wa = r_free[AW-1:0]; lnk_wd = r_cur;
        resv_clr = 1'b0; resv_set = 1'b0;
        raddr = r_cur[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cur = r_head; n_prev = PTR_NIL; n_status = ST_OK; n_res = 16'd0;
                    n_state = (r_head >= PTR_W'(ENTRIES)) ? S_DONE : S_RD;
                    unique case (i_opcode)
                        OP_FIXED: begin
                            n_p = {1'b0, i_port};
                            if (({2'b00, i_port} + {1'b0, i_size}) > {1'b0, r_limit}) begin
                                n_status = ST_NOSPC; n_state = S_DONE;
                            end else if (r_head >= PTR_W'(ENTRIES)) begin
                                n_res = i_port;
                                if (free_nil) begin
                                    n_status = ST_NOENT;
                                end else begin
                                    n_state = S_INSR;
                                end
                            end
                        end
                        OP_SEARCH, OP_RESV: begin
                            n_p = {1'b0, r_floor};
                            if (r_head >= PTR_W'(ENTRIES)) begin
                                n_status = ST_NOSPC;
                            end
                        end
                        OP_FREE: n_res = i_port;
                        OP_CHECK: begin
                            n_res = i_port;
                            if ((i_port >= VGA_A_LO && i_range_end <= VGA_A_HI) ||
                                (i_port >= VGA_B_LO && i_range_end <= VGA_B_HI)) begin
                                n_state = S_DONE;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RD: n_state = S_EV;
            S_EV: begin
                // default step: move along the list
                n_prev = r_cur; n_cur = lnk_q; n_nx = lnk_q;
                n_state = (lnk_q >= PTR_W'(ENTRIES)) ? S_DONE : S_RD;
                unique case (r_op)
                    OP_FIXED: begin
                        if ({1'b0, re} <= {2'b00, r_port}) begin
                            if (lnk_q >= PTR_W'(ENTRIES)) begin
                                n_res = r_port;
                                if (free_nil) begin
                                    n_status = ST_NOENT; n_state = S_DONE;
                                end else begin
                                    n_state = S_INSR;
                                end
                            end
                        end else begin
                            n_cur = r_cur; n_prev = r_prev; n_state = S_DONE;
                            if (r_resv[r_cur[AW-1:0]] && rs == r_port && {1'b0, re} == end0) begin
                                resv_clr = 1'b1; n_res = r_port;
                            end else if ({2'b00, rs} >= end0) begin
                                n_res = r_port;
                                if (free_nil) begin
                                    n_status = ST_NOENT;
                                end else begin
                                    n_state = S_INSR;
                                end
                            end else begin
                                n_status = ST_NOSPC; n_res = 16'd0;
                            end
                        end
                    end
                    OP_SEARCH, OP_RESV: begin
                        if (rs >= r_floor && {2'b00, rs} > psz) begin
                            n_cur = r_cur; n_prev = r_prev; n_state = S_DONE;
                            n_res = r_p[15:0];
                            if (free_nil) begin
                                n_status = ST_NOENT;
                            end else begin
                                n_state = S_INSR;
                            end
                        end else begin
                            if (rs >= r_floor) begin
                                if (r_align != 16'd0) begin
                                    // round up: p = n - (n mod align), n = stop + align - 1
                                    n_p = re + {1'b0, r_align} - 17'd1;
                                    n_dvd = re + {1'b0, r_align} - 17'd1;
                                    n_rem = 16'd0; n_cnt = 5'd16; n_state = S_DIV;
                                end else begin
                                    n_p = re;
                                end
                            end
                            if (lnk_q >= PTR_W'(ENTRIES) && n_state == S_DONE) begin
                                n_status = ST_NOSPC;
                            end
                        end
                    end
                    OP_FREE: begin
                        if (rs == r_port) begin
                            n_cur = r_cur; n_prev = r_prev; n_state = S_FR1;
                        end else if (rs > r_port) begin
                            n_cur = r_cur; n_prev = r_prev; n_state = S_DONE;
                        end
                    end
                    OP_CHECK: begin
                        if ((r_port >= rs && {1'b0, r_port} < re) ||
                            (r_port <= rs && r_rend > {1'b0, rs})) begin
                            n_status = ST_DENIED; n_state = S_DONE;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_DIV: begin
                if (rem_sh >= {1'b0, r_align}) begin
                    n_rem = 16'(rem_sh - {1'b0, r_align});
                end else begin
                    n_rem = rem_sh[15:0];
                end
                n_dvd = {r_dvd[15:0], 1'b0};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_p = r_p - {1'b0, n_rem};
                    if (cur_nil) begin
                        n_status = ST_NOSPC; n_state = S_DONE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_INSR: begin
                raddr = r_free[AW-1:0];
                rng_we = 1'b1;
                n_state = S_INS1;
            end
            S_INS1: begin
                lnk_we = 1'b1;
                resv_set = (r_op == OP_RESV);
                n_ent = r_free; n_free = lnk_q;
                n_state = S_INS2;
            end
            S_INS2: begin
                if (r_prev >= PTR_W'(ENTRIES)) begin
                    n_head = r_ent;
                end else begin
                    lnk_we = 1'b1; lnk_wa = r_prev[AW-1:0]; lnk_wd = r_ent;
                end
                n_count = r_count + 32'd1;
                n_state = S_DONE;
            end
            S_FR1: begin
                if (r_prev >= PTR_W'(ENTRIES)) begin
                    n_head = r_nx;
                end else begin
                    lnk_we = 1'b1; lnk_wa = r_prev[AW-1:0]; lnk_wd = r_nx;
                end
                n_state = S_FR2;
            end
            S_FR2: begin
                lnk_we = 1'b1; lnk_wa = r_cur[AW-1:0];
                lnk_wd = free_nil ? PTR_NIL : r_free;
                n_free = r_cur;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_go) begin
                    n_count = ver;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= PTR_NIL;
            r_free  <= '0;
            r_count <= '0;
            r_resv  <= '0;
            r_lvld  <= '0;
            r_floor <= FLOOR_RST;
            r_limit <= LIMIT_RST;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_count <= n_count;
            if (resv_clr) begin
                r_resv[r_cur[AW-1:0]] <= 1'b0;
            end
            if (resv_set) begin
                r_resv[r_free[AW-1:0]] <= 1'b1;
            end else if (r_state == S_INS1) begin
                r_resv[r_free[AW-1:0]] <= 1'b0;
            end
            if (lnk_we) begin
                r_lvld[lnk_wa] <= 1'b1;
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_FLOOR) begin
                    r_floor <= pwdata[15:0];
                end else begin
                    r_limit <= pwdata[16:0];
                end
            end
            if (r_state == S_DONE && out_go) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur; r_prev <= n_prev; r_ent <= n_ent; r_nx <= n_nx;
        r_p <= n_p; r_dvd <= n_dvd; r_rem <= n_rem; r_cnt <= n_cnt;
        r_status <= n_status; r_res <= n_res; r_raddr <= raddr;
        if (in_acc) begin
            r_op <= i_opcode; r_port <= i_port; r_size <= i_size;
            r_align <= i_align; r_rend <= i_range_end;
        end
        if (r_state == S_DONE && out_go) begin
            o_status <= r_status;
            o_result_port <= r_res;
            o_table_version <= ver;
        end
    end

    `IOPRA_ASSERT_NEXT(a_busy_after_accept, in_acc, !o_in_ready, "ready while busy")
    `IOPRA_ASSERT_NEXT(a_read_then_eval, r_state == S_RD, r_state == S_EV, "read not evaluated")
    `IOPRA_ASSERT_NOW(a_insert_has_entry, r_state == S_INSR, !free_nil, "insert with no free entry")
    `IOPRA_ASSERT_NOW(a_div_count, r_state == S_DIV, r_cnt <= 5'd16 && r_align != 16'd0,
        "remainder unit out of range")
endmodule
`default_nettype wire

// ===== tb/sv/io_port_range_allocator_unit_checker.sv =====
// Checker for the I/O port range allocator: watches the request, result and APB channels,
// keeps its own copy of the range table and compares every result in order.
// Depends on iopra_pkg.
`default_nettype none
module io_port_range_allocator_unit_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire  [2:0]  i_opcode,
    input  wire  [15:0] i_port,
    input  wire  [16:0] i_size,
    input  wire  [15:0] i_align,
    input  wire  [16:0] i_range_end,
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire  [1:0]  i_status,
    input  wire  [15:0] i_result_port,
    input  wire  [31:0] i_table_version,
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire  [2:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    input  wire         i_pready,
    output int          o_errors,
    output int          o_pending
);
    import iopra_pkg::*;

    localparam int unsigned N = ENTRIES_DEF;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] port;
        logic [31:0] version;
    } t_grant;

    logic [15:0]      floor_q;
    logic [16:0]      limit_q;
    logic [15:0]      rng_lo  [N];
    logic [16:0]      rng_hi  [N];
    logic             rng_rsv [N];
    logic [PTR_W-1:0] rng_nxt [N];
    logic [PTR_W-1:0] used_head;
    logic [PTR_W-1:0] spare_head;
    logic [31:0]      version_q;
    t_grant           grants_due[$];

    assign o_pending = grants_due.size();

    function automatic logic [PTR_W-1:0] step_of(logic [PTR_W-1:0] idx);
        if (idx >= N) return PTR_NIL;
        return (rng_nxt[idx] < N) ? rng_nxt[idx] : PTR_NIL;
    endfunction

    // link a fresh entry between prev and cur; out of entries leaves the table alone
    function automatic logic [1:0] link_range(logic [PTR_W-1:0] prev, logic [PTR_W-1:0] cur,
                                              int unsigned lo, int unsigned sz, logic rsv);
        logic [PTR_W-1:0] e;
        e = spare_head;
        if (e >= N) return ST_NOENT;
        spare_head  = step_of(e);
        rng_nxt[e]  = cur;
        rng_lo[e]   = lo[15:0];
        rng_hi[e]   = 17'((lo + sz) & 32'h1ffff);
        rng_rsv[e]  = rsv;
        if (prev == PTR_NIL) used_head = e;
        else rng_nxt[prev] = e;
        version_q++;
        return ST_OK;
    endfunction

    function automatic t_grant allocate(logic [2:0] op, int unsigned port, int unsigned size,
                                        int unsigned align, int unsigned rend);
        t_grant           g;
        logic [PTR_W-1:0] prev, cur, nx;
        int unsigned      steps, p;
        logic             hit;
        g = '0;
        prev = PTR_NIL;
        cur = (used_head < N) ? used_head : PTR_NIL;
        steps = 0;
        hit = 1'b0;
        case (op)
            OP_FIXED: begin
                g.status = ST_NOSPC;
                if (port + size <= limit_q) begin
                    g.status = ST_OK;
                    for (; cur != PTR_NIL && steps < N; steps++) begin
                        if (rng_hi[cur] <= port) begin
                            prev = cur;
                            cur = step_of(cur);
                            continue;
                        end
                        if (rng_rsv[cur] && rng_lo[cur] == port && rng_hi[cur] == port + size) begin
                            rng_rsv[cur] = 1'b0;
                            hit = 1'b1;
                            break;
                        end
                        if (rng_lo[cur] >= port + size) break;
                        g.status = ST_NOSPC;
                        break;
                    end
                    if (hit) g.port = port[15:0];
                    else if (g.status == ST_OK) begin
                        g.status = link_range(prev, cur, port, size, 1'b0);
                        g.port = port[15:0];
                    end
                end
            end
            OP_SEARCH, OP_RESV: begin
                p = floor_q;
                for (; cur != PTR_NIL && steps < N; steps++) begin
                    if (rng_lo[cur] >= floor_q) begin
                        if (rng_lo[cur] > p + size) break;
                        p = rng_hi[cur];
                        if (align != 0) p = ((p + align - 1) / align) * align;
                    end
                    prev = cur;
                    cur = step_of(cur);
                end
                if (cur == PTR_NIL || steps >= N) g.status = ST_NOSPC;
                else begin
                    g.status = link_range(prev, cur, p, size, op == OP_RESV);
                    g.port = p[15:0];
                end
            end
            OP_FREE: begin
                for (; cur != PTR_NIL && steps < N; steps++) begin
                    if (rng_lo[cur] == port) begin
                        nx = step_of(cur);
                        if (prev == PTR_NIL) used_head = nx;
                        else rng_nxt[prev] = nx;
                        rng_nxt[cur] = (spare_head < N) ? spare_head : PTR_NIL;
                        spare_head = cur;
                        break;
                    end
                    if (rng_lo[cur] > port) break;
                    prev = cur;
                    cur = step_of(cur);
                end
                version_q++;
                g.port = port[15:0];
            end
            OP_CHECK: begin
                g.port = port[15:0];
                // the two VGA windows are always permitted
                if (!((port >= VGA_A_LO && rend <= VGA_A_HI) ||
                      (port >= VGA_B_LO && rend <= VGA_B_HI))) begin
                    for (; cur != PTR_NIL && steps < N; steps++) begin
                        if ((port >= rng_lo[cur] && port < rng_hi[cur]) ||
                            (port <= rng_lo[cur] && rend > rng_lo[cur])) begin
                            g.status = ST_DENIED;
                            break;
                        end
                        cur = step_of(cur);
                    end
                end
            end
            default: ;
        endcase
        if (g.status == ST_NOSPC) g.port = '0;
        g.version = version_q;
        return g;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                rng_lo[i] = '0;
                rng_hi[i] = '0;
                rng_rsv[i] = 1'b0;
                rng_nxt[i] = (i + 1 < N) ? PTR_W'(i + 1) : PTR_NIL;
            end
            used_head = PTR_NIL;
            spare_head = '0;
            version_q = '0;
            floor_q = FLOOR_RST;
            limit_q = LIMIT_RST;
            grants_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (grants_due.size() == 0) begin
                    $display("unexpected result transfer at %0t", $realtime);
                    o_errors++;
                end else begin
                    want = grants_due.pop_front();
                    if (i_status != want.status) report("status", i_status, want.status);
                    if (i_result_port != want.port) report("result_port", i_result_port, want.port);
                    if (i_table_version != want.version)
                        report("table_version", i_table_version, want.version);
                end
            end
            if (i_in_valid && i_in_ready)
                grants_due.push_back(allocate(i_opcode, i_port, i_size, i_align, i_range_end));
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_LIMIT) limit_q = i_pwdata[16:0];
                else floor_q = i_pwdata[15:0];
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/io_port_range_allocator_unit_tb.sv =====
// Top of the allocator testbench: clock, reset, request and APB stimulus, verdict.
// Depends on iopra_pkg, io_port_range_allocator_unit and io_port_range_allocator_unit_checker.
`default_nettype none
module io_port_range_allocator_unit_tb;
    import iopra_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 700;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [2:0]  i_opcode = '0;
    logic [15:0] i_port = '0;
    logic [16:0] i_size = '0;
    logic [15:0] i_align = '0;
    logic [16:0] i_range_end = '0;
    logic        i_out_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         o_in_ready, o_out_valid, pready;
    wire  [1:0]  o_status;
    wire  [15:0] o_result_port;
    wire  [31:0] o_table_version;
    wire  [31:0] prdata;
    int          errors, pending;
    int          tx_idle_pct = 0, rx_idle_pct = 0;
    bit          rx_hold = 1'b0;
    int          quiet_cycles = 0;
    logic [15:0] floor_now = FLOOR_RST;

    io_port_range_allocator_unit uut (.*);

    io_port_range_allocator_unit_checker chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_opcode, .i_port, .i_size,
        .i_align, .i_range_end, .i_out_valid(o_out_valid), .i_out_ready, .i_status(o_status),
        .i_result_port(o_result_port), .i_table_version(o_table_version), .i_psel(psel),
        .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr), .i_pwdata(pwdata),
        .i_pready(pready), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side backpressure
    always @(negedge i_clk) begin
        i_out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_op(t_op op, logic [15:0] port, logic [16:0] size,
                           logic [15:0] align, logic [16:0] rend);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_port <= port;
        i_size <= size;
        i_align <= align;
        i_range_end <= rend;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_regs(logic [15:0] fl, logic [16:0] lim);
        drain();
        apb_write(3'd0, {16'd0, fl});
        apb_write(3'd4, {15'd0, lim});
        floor_now = fl;
    endtask

    // mostly ports on a coarse grid near the floor so that frees and overlaps hit
    task automatic random_ops(int count);
        t_op         op;
        logic [15:0] port, align;
        logic [16:0] size, rend;
        int          pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) op = OP_FIXED;
            else if (pick < 50) op = OP_SEARCH;
            else if (pick < 60) op = OP_RESV;
            else if (pick < 85) op = OP_FREE;
            else if (pick < 97) op = OP_CHECK;
            else op = t_op'(3'($urandom_range(5, 7)));
            port = floor_now + 16'($urandom_range(0, 47) * 32);
            size = 17'($urandom_range(1, 64));
            align = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 64)) : 16'd0;
            rend = 17'(port) + 17'($urandom_range(0, 96));
            if ($urandom_range(0, 9) == 0) begin
                port = 16'($urandom);
                size = 17'($urandom_range(0, 65536));
                align = 16'($urandom);
                rend = 17'($urandom_range(0, 65536));
            end
            send_op(op, port, size, align, rend);
        end
    endtask

    initial begin
        tx_idle_pct = 11;
        rx_idle_pct = 87;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every operation, VGA windows, reserved exact match
        send_op(OP_FIXED, 16'h0000, 17'h00010, 16'd0, 17'd0);
        send_op(OP_FIXED, 16'h0008, 17'h00004, 16'd0, 17'd0);
        send_op(OP_FIXED, 16'hffff, 17'h00001, 16'd0, 17'd0);
        send_op(OP_FIXED, 16'h0000, 17'h10000, 16'd0, 17'd0);
        send_op(OP_FIXED, 16'h1000, 17'h00000, 16'd0, 17'd0);
        send_op(OP_SEARCH, 16'd0, 17'h00000, 16'd0, 17'd0);
        send_op(OP_SEARCH, 16'd0, 17'h00020, 16'hffff, 17'd0);
        send_op(OP_SEARCH, 16'd0, 17'h00010, 16'h0100, 17'd0);
        send_op(OP_RESV, 16'd0, 17'h00008, 16'd0, 17'd0);
        send_op(OP_FIXED, 16'h0400, 17'h00008, 16'd0, 17'd0);
        send_op(OP_SEARCH, 16'd0, 17'h1ffff, 16'd0, 17'd0);
        send_op(OP_CHECK, VGA_A_LO, 17'd0, 16'd0, VGA_A_HI);
        send_op(OP_CHECK, VGA_B_LO, 17'd0, 16'd0, VGA_B_HI);
        send_op(OP_CHECK, 16'h0002, 17'd0, 16'd0, 17'h00004);
        send_op(OP_CHECK, 16'h0020, 17'd0, 16'd0, 17'h00040);
        send_op(OP_CHECK, 16'h0000, 17'd0, 16'd0, 17'h1ffff);
        send_op(OP_FREE, 16'h0000, 17'd0, 16'd0, 17'd0);
        send_op(OP_FREE, 16'h0123, 17'd0, 16'd0, 17'd0);
        send_op(OP_FREE, 16'hffff, 17'd0, 16'd0, 17'd0);
        send_op(t_op'(3'd5), 16'hffff, 17'h1ffff, 16'hffff, 17'h1ffff);
        send_op(t_op'(3'd7), 16'h0000, 17'd0, 16'd0, 17'd0);

        set_regs(16'h0000, 17'h10000);
        random_ops(200);

        set_regs(16'hffff, 17'h00001);
        random_ops(30);

        set_regs(16'h2000, 17'h09000);
        tx_idle_pct = 87;
        rx_idle_pct = 11;
        random_ops(180);

        // long receiver stall while requests keep coming
        fork
            begin
                rx_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            random_ops(8);
        join

        set_regs(FLOOR_RST, LIMIT_RST);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_ops(200);

        drain();
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== io_port_range_allocator_unit.f =====
+incdir+src
src/iopra_pkg.sv
src/iopra_ram.sv
src/io_port_range_allocator_unit.sv
tb/sv/io_port_range_allocator_unit_checker.sv
tb/sv/io_port_range_allocator_unit_tb.sv
